// ===== rtl/itsm_pkg.sv =====
// itsm_pkg: shared types and codes for the interval timer counter core
// no dependencies; used by interval_timer_six_modes_core

package itsm_pkg;

  // item kind carried on func
  typedef enum logic {
    FUNC_PULSE = 1'b0,
    FUNC_LOAD  = 1'b1
  } func_e;

  // counting modes, six and seven hold the output
  typedef enum logic [2:0] {
    MODE_INT_ON_TC    = 3'd0,
    MODE_ONE_SHOT     = 3'd1,
    MODE_RATE_GEN     = 3'd2,
    MODE_SQUARE_WAVE  = 3'd3,
    MODE_SW_STROBE    = 3'd4,
    MODE_HW_STROBE    = 3'd5,
    MODE_HOLD_6       = 3'd6,
    MODE_HOLD_7       = 3'd7
  } mode_e;

  // pulse phase saturates at two
  localparam int unsigned PhaseW = 2;
  typedef logic [PhaseW-1:0] phase_t;
  localparam phase_t PHASE_IDLE  = 2'd0;
  localparam phase_t PHASE_FIRST = 2'd1;
  localparam phase_t PHASE_SAT   = 2'd2;

endpackage

// ===== rtl/interval_timer_six_modes_core.sv =====
// interval_timer_six_modes_core: one counter of an 8253-style interval timer
// depends on itsm_pkg for mode, item kind and pulse phase codes

// Each input word is either a load (mode, LSB-only flag, 8-bit count) or one
// clock pulse carrying the sampled gate level; every word returns the output
// level and the signed count, which holds at -1 once it passes terminal.
// The counter state is updated by a single pass of combinational logic at
// acceptance and the result lands in an output register, so a new word is
// accepted in every cycle while the result side keeps taking words. The
// result register only throttles input when a held result is not taken.
// Pulses change nothing unless the last load set LSB-only.

module interval_timer_six_modes_core #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic                        gate_i,
  input  logic [2:0]                  load_mode_i,
  input  logic                        load_lsb_only_i,
  input  logic [7:0]                  load_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_level_o,
  output logic signed [COUNT_WIDTH:0] count_value_o
);

  typedef logic signed [COUNT_WIDTH:0] cnt_t;
  localparam cnt_t CntNegOne = '1;
  localparam cnt_t CntZero   = '0;
  localparam cnt_t CntOne    = cnt_t'(1);

  // counter state
  cnt_t                     count_q, count_d;
  logic [COUNT_WIDTH-1:0]   reload_q, reload_d;
  itsm_pkg::mode_e          mode_q, mode_d;
  logic                     lsb_only_q, lsb_only_d;
  itsm_pkg::phase_t         phase_q, phase_d;
  logic                     term_q, term_d;
  logic                     out_q, out_d;

  // result register
  logic                     res_valid_q;
  logic                     res_level_q;
  cnt_t                     res_count_q;

  logic                     accept;
  cnt_t                     rl;
  cnt_t                     rl_half;

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign rl      = $signed({1'b0, reload_q});
  assign rl_half = $signed({2'b00, reload_q[COUNT_WIDTH-1:1]});

  function automatic cnt_t dec_sat(input cnt_t c);
    if (c != CntNegOne) begin
      return c - CntOne;
    end
    return c;
  endfunction

  function automatic itsm_pkg::phase_t phase_inc(input itsm_pkg::phase_t p);
    if (p != itsm_pkg::PHASE_SAT) begin
      return p + itsm_pkg::phase_t'(1);
    end
    return p;
  endfunction

  always_comb begin
    count_d    = count_q;
    reload_d   = reload_q;
    mode_d     = mode_q;
    lsb_only_d = lsb_only_q;
    phase_d    = phase_q;
    term_d     = term_q;
    out_d      = out_q;

    if (itsm_pkg::func_e'(func_i) == itsm_pkg::FUNC_LOAD) begin
      reload_d   = COUNT_WIDTH'(load_count_i);
      count_d    = $signed({1'b0, COUNT_WIDTH'(load_count_i)});
      mode_d     = itsm_pkg::mode_e'(load_mode_i);
      lsb_only_d = load_lsb_only_i;
      term_d     = 1'b0;
      if (itsm_pkg::mode_e'(load_mode_i) == itsm_pkg::MODE_ONE_SHOT) begin
        out_d = 1'b1;
      end
    end else if (lsb_only_q) begin
      case (mode_q)
        itsm_pkg::MODE_INT_ON_TC: begin
          phase_d = phase_inc(phase_d);
          if (term_d) begin
            out_d = 1'b1;
          end else if (gate_i) begin
            if (count_d == CntZero) begin
              term_d = 1'b1;
              out_d  = 1'b1;
            end else begin
              if (phase_d != itsm_pkg::PHASE_FIRST) begin
                count_d = dec_sat(count_d);
              end
              out_d = 1'b0;
            end
          end else begin
            phase_d = itsm_pkg::PHASE_IDLE;
            out_d   = 1'b0;
          end
        end
        itsm_pkg::MODE_ONE_SHOT: begin
          if (!gate_i) begin
            phase_d = itsm_pkg::PHASE_IDLE;
            count_d = rl;
            out_d   = 1'b1;
          end
          if (phase_d == itsm_pkg::PHASE_IDLE && !gate_i) begin
            out_d   = 1'b1;
            phase_d = itsm_pkg::PHASE_FIRST;
          end
          if (phase_d == itsm_pkg::PHASE_FIRST) begin
            if (gate_i) begin
              out_d   = 1'b0;
              count_d = dec_sat(count_d);
              phase_d = phase_inc(phase_d);
            end
          end else if (gate_i) begin
            if (count_d == CntZero) begin
              out_d = 1'b1;
            end else if (count_d < rl && count_d > CntZero) begin
              count_d = dec_sat(count_d);
              out_d   = 1'b0;
            end else begin
              out_d = 1'b1;
            end
            phase_d = phase_inc(phase_d);
          end
        end
        itsm_pkg::MODE_RATE_GEN: begin
          phase_d = phase_inc(phase_d);
          if (gate_i) begin
            if (count_d != CntOne) begin
              if (phase_d != itsm_pkg::PHASE_FIRST) begin
                count_d = dec_sat(count_d);
              end
              out_d = 1'b1;
            end else begin
              out_d   = 1'b0;
              count_d = rl;
            end
          end else begin
            count_d = rl;
          end
        end
        itsm_pkg::MODE_SQUARE_WAVE: begin
          if (!gate_i) begin
            phase_d = itsm_pkg::PHASE_IDLE;
            count_d = rl;
          end
          if (phase_d == itsm_pkg::PHASE_IDLE) begin
            out_d = 1'b1;
            if (gate_i) begin
              phase_d = phase_inc(phase_d);
            end
          end else if (count_d == CntOne) begin
            out_d   = 1'b0;
            count_d = rl;
            phase_d = phase_inc(phase_d);
          end else begin
            out_d   = (count_d > rl_half);
            count_d = dec_sat(count_d);
            phase_d = phase_inc(phase_d);
          end
        end
        itsm_pkg::MODE_SW_STROBE: begin
          phase_d = phase_inc(phase_d);
          if (count_d != CntZero) begin
            if (gate_i && phase_d != itsm_pkg::PHASE_FIRST) begin
              count_d = dec_sat(count_d);
            end
            out_d = 1'b1;
          end else begin
            out_d   = 1'b0;
            count_d = dec_sat(count_d);
          end
        end
        itsm_pkg::MODE_HW_STROBE: begin
          if (!gate_i) begin
            phase_d = itsm_pkg::PHASE_IDLE;
            count_d = rl;
          end
          if (phase_d == itsm_pkg::PHASE_IDLE) begin
            if (!gate_i) begin
              out_d   = 1'b1;
              phase_d = itsm_pkg::PHASE_FIRST;
            end
          end else if (phase_d == itsm_pkg::PHASE_FIRST) begin
            if (gate_i) begin
              count_d = dec_sat(count_d);
              phase_d = phase_inc(phase_d);
            end
            out_d = 1'b1;
          end else if (gate_i) begin
            if (count_d == CntZero) begin
              out_d   = 1'b0;
              count_d = dec_sat(count_d);
            end else if (count_d < rl && count_d > CntZero) begin
              count_d = dec_sat(count_d);
              out_d   = 1'b1;
            end else begin
              out_d = 1'b1;
            end
            phase_d = phase_inc(phase_d);
          end
        end
        default: begin
          // hold modes: nothing moves
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CntZero;
      reload_q   <= '0;
      mode_q     <= itsm_pkg::MODE_INT_ON_TC;
      lsb_only_q <= 1'b0;
      phase_q    <= itsm_pkg::PHASE_IDLE;
      term_q     <= 1'b0;
      out_q      <= 1'b0;
    end else if (accept) begin
      count_q    <= count_d;
      reload_q   <= reload_d;
      mode_q     <= mode_d;
      lsb_only_q <= lsb_only_d;
      phase_q    <= phase_d;
      term_q     <= term_d;
      out_q      <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_level_q <= out_d;
      res_count_q <= count_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign out_level_o   = res_level_q;
  assign count_value_o = res_count_q;

endmodule
